>>> rtl/thfc_pkg.sv
// Package for the TCP header flag classifier: status and class codes,
// header offsets, TCP flag masks, the result record and the flag decoder.
// Self-contained; imported by tcp_header_flag_classifier.
package thfc_pkg;

  // Frame byte counter width and its saturation value.
  localparam int unsigned OFFSET_W = 11;
  localparam logic [OFFSET_W-1:0] OFFSET_CAP = 11'd2047;

  // Captured-length width: one more bit than the byte counter.
  localparam int unsigned CAPT_W = OFFSET_W + 1;

  // Fixed positions in the Ethernet and IPv4 headers.
  localparam logic [OFFSET_W-1:0] ETH_BYTES     = 11'd14;
  localparam logic [OFFSET_W-1:0] IP_PROTO_POS  = 11'd23;
  localparam logic [OFFSET_W-1:0] IP_ADDR_FIRST = 11'd26;
  localparam int unsigned IP_ADDR_BYTES = 8;

  // Minimum captured lengths for the IP length byte and the IP addresses.
  localparam logic [CAPT_W-1:0] MIN_CAPT_IHL  = 12'd15;
  localparam logic [CAPT_W-1:0] MIN_CAPT_ADDR = 12'd34;

  // Header length limits and the TCP protocol number.
  localparam logic [5:0] MIN_HDR_BYTES = 6'd20;
  localparam logic [7:0] PROTO_TCP     = 8'd6;

  // Positions inside the TCP header, relative to its first byte.
  localparam logic [3:0] TCP_PORTS_SEQ_BYTES = 4'd8;
  localparam logic [3:0] TCP_ACK_END         = 4'd12;
  localparam logic [3:0] TCP_OFFSET_POS      = 4'd12;
  localparam logic [3:0] TCP_FLAGS_POS       = 4'd13;
  localparam logic [3:0] TCP_CAPT_BYTES      = 4'd14;

  // TCP flag masks.
  localparam logic [4:0] FLAG_FIN = 5'h01;
  localparam logic [4:0] FLAG_SYN = 5'h02;
  localparam logic [4:0] FLAG_RST = 5'h04;
  localparam logic [4:0] FLAG_PSH = 5'h08;
  localparam logic [4:0] FLAG_ACK = 5'h10;

  // Number of counted flag classes.
  localparam int unsigned NUM_CLASSES = 6;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_IP_LEN = 3'd1,
    ST_NOT_TCP    = 3'd2,
    ST_BAD_TCP_OFF = 3'd3,
    ST_ZERO_PORT  = 3'd4,
    ST_TRUNCATED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CLS_ACK      = 3'd0,
    CLS_PUSH_ACK = 3'd1,
    CLS_FIN_ACK  = 3'd2,
    CLS_RST_ACK  = 3'd3,
    CLS_SYN      = 3'd4,
    CLS_SYN_ACK  = 3'd5,
    CLS_OTHER    = 3'd6
  } flag_class_t;

  // One result word.
  typedef struct packed {
    flag_class_t flag_class;
    status_t     status;
    logic [31:0] class_count;
    logic [31:0] packet_number;
    logic [31:0] acknowledge_number;
    logic [31:0] sequence_number;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [31:0] dest_address;
    logic [31:0] source_address;
  } result_t;

  // Map the five low TCP flag bits onto a class; ECE, CWR and URG are ignored.
  function automatic flag_class_t classify(input logic [7:0] flags);
    flag_class_t cls;
    unique case (flags[4:0])
      FLAG_ACK:            cls = CLS_ACK;
      FLAG_PSH | FLAG_ACK: cls = CLS_PUSH_ACK;
      FLAG_FIN | FLAG_ACK: cls = CLS_FIN_ACK;
      FLAG_RST | FLAG_ACK: cls = CLS_RST_ACK;
      FLAG_SYN:            cls = CLS_SYN;
      FLAG_SYN | FLAG_ACK: cls = CLS_SYN_ACK;
      default:             cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

>>> rtl/tcp_header_flag_classifier.sv
// The result of the last frame byte is registered in the output register, or in the skid entry if that one is held.
// One frame byte per cycle while s_axis_tready is high; the parse registers take every accepted byte.
// The output register plus one skid entry let input continue while a result waits;
// s_axis_tready drops only when both hold a result.
// Reset (rst, synchronous): clears the parse state, output valids and class counters,
// and sets the packet counter to one.
module tcp_header_flag_classifier #(
  parameter int unsigned MAX_FRAME_BYTES = 1518
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] frame_byte
  input  logic         s_axis_tlast,   // frame_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] source_address, [63:32] dest_address, [79:64] source_port,
  // [95:80] dest_port, [127:96] sequence_number, [159:128] acknowledge_number,
  // [191:160] packet_number, [223:192] class_count
  output logic [223:0] m_axis_tdata,
  output logic [5:0]   m_axis_tuser    // [2:0] status, [5:3] flag_class
);
  import thfc_pkg::*;

  // Parse state for the frame in progress.
  logic [OFFSET_W-1:0] byte_offset;
  logic [5:0]          ip_header_bytes;
  logic [5:0]          tcp_header_bytes;
  logic [7:0]          protocol_byte;
  logic [63:0]         addr_field;
  logic [63:0]         tcp_field;
  logic [31:0]         ack_field;
  logic [7:0]          flag_bits;
  logic [31:0]         frame_counter;
  logic [31:0]         class_counters [NUM_CLASSES];

  // Output register and skid entry.
  result_t out_word;
  logic    out_valid;
  result_t skid_word;
  logic    skid_valid;

  // Values after taking the current byte.
  logic [5:0]          ip_header_bytes_next;
  logic [5:0]          tcp_header_bytes_next;
  logic [7:0]          protocol_byte_next;
  logic [63:0]         addr_field_next;
  logic [63:0]         tcp_field_next;
  logic [31:0]         ack_field_next;
  logic [7:0]          flag_bits_next;
  logic [31:0]         frame_counter_next;
  logic [OFFSET_W-1:0] byte_offset_next;

  logic                take;
  logic [6:0]          tcp_start;
  logic [OFFSET_W-1:0] tcp_rel;
  logic                in_tcp;
  logic [CAPT_W-1:0]   capt_raw;
  logic [CAPT_W-1:0]   captured;
  logic [6:0]          tcp_start_next;
  logic [CAPT_W-1:0]   tcp_flags_end;
  logic [CAPT_W-1:0]   tcp_hdr_end;
  logic                show_ip;
  logic                show_tcp;
  logic                counted;
  logic [2:0]          cls_idx;
  logic [31:0]         cls_count;
  status_t             status;
  flag_class_t         cls;
  result_t             result;

  logic accept;
  logic push;
  logic pop;

  assign s_axis_tready = !skid_valid;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign push   = accept && s_axis_tlast;
  assign pop    = out_valid && m_axis_tready;

  // Byte capture: place the incoming byte into its header field.
  always_comb begin
    take                  = (32'(byte_offset) < MAX_FRAME_BYTES);
    ip_header_bytes_next  = ip_header_bytes;
    protocol_byte_next    = protocol_byte;
    addr_field_next       = addr_field;
    tcp_field_next        = tcp_field;
    ack_field_next        = ack_field;
    tcp_header_bytes_next = tcp_header_bytes;
    flag_bits_next        = flag_bits;
    tcp_start             = 7'(ETH_BYTES) + {1'b0, ip_header_bytes};
    tcp_rel               = byte_offset - OFFSET_W'(tcp_start);
    in_tcp                = take && (ip_header_bytes >= MIN_HDR_BYTES) &&
                            (byte_offset >= OFFSET_W'(tcp_start)) &&
                            (tcp_rel < OFFSET_W'(TCP_CAPT_BYTES));
    if (take && byte_offset == ETH_BYTES) begin
      ip_header_bytes_next = {s_axis_tdata[3:0], 2'b00};
    end
    if (take && byte_offset == IP_PROTO_POS) begin
      protocol_byte_next = s_axis_tdata;
    end
    for (int i = 0; i < IP_ADDR_BYTES; i++) begin
      if (take && byte_offset == IP_ADDR_FIRST + OFFSET_W'(i)) begin
        addr_field_next[63-8*i -: 8] = s_axis_tdata;
      end
    end
    if (in_tcp) begin
      for (int i = 0; i < 8; i++) begin
        if (tcp_rel[3:0] == 4'(i)) begin
          tcp_field_next[63-8*i -: 8] = s_axis_tdata;
        end
      end
      for (int i = 0; i < 4; i++) begin
        if (tcp_rel[3:0] == TCP_PORTS_SEQ_BYTES + 4'(i)) begin
          ack_field_next[31-8*i -: 8] = s_axis_tdata;
        end
      end
      if (tcp_rel[3:0] == TCP_OFFSET_POS) begin
        tcp_header_bytes_next = {s_axis_tdata[7:4], 2'b00};
      end
      if (tcp_rel[3:0] == TCP_FLAGS_POS) begin
        flag_bits_next = s_axis_tdata;
      end
    end
  end

  // Frame checks and classification on the final byte.
  always_comb begin
    capt_raw       = {1'b0, byte_offset} + CAPT_W'(1);
    captured       = (32'(capt_raw) > MAX_FRAME_BYTES) ? CAPT_W'(MAX_FRAME_BYTES) : capt_raw;
    tcp_start_next = 7'(ETH_BYTES) + {1'b0, ip_header_bytes_next};
    tcp_flags_end  = CAPT_W'(tcp_start_next) + CAPT_W'(TCP_CAPT_BYTES) - CAPT_W'(1);
    tcp_hdr_end    = CAPT_W'(tcp_start_next) + CAPT_W'(tcp_header_bytes_next);
    status         = ST_OK;
    cls            = CLS_OTHER;
    show_ip        = 1'b0;
    show_tcp       = 1'b0;
    if (captured < MIN_CAPT_IHL) begin
      status = ST_TRUNCATED;
    end else if (ip_header_bytes_next < MIN_HDR_BYTES) begin
      status = ST_BAD_IP_LEN;
    end else begin
      show_ip = 1'b1;
      if (captured < MIN_CAPT_ADDR) begin
        status = ST_TRUNCATED;
      end else if (protocol_byte_next != PROTO_TCP) begin
        status = ST_NOT_TCP;
      end else begin
        show_tcp = 1'b1;
        if (captured < tcp_flags_end) begin
          status = ST_TRUNCATED;
        end else if (tcp_header_bytes_next < MIN_HDR_BYTES) begin
          status = ST_BAD_TCP_OFF;
        end else if (tcp_field_next[63:48] == 16'd0 || tcp_field_next[47:32] == 16'd0) begin
          status = ST_ZERO_PORT;
        end else if (captured < tcp_hdr_end) begin
          status = ST_TRUNCATED;
        end else begin
          cls = classify(flag_bits_next);
        end
      end
    end
    frame_counter_next = frame_counter + 32'(show_ip);
    counted            = (cls != CLS_OTHER);
    cls_idx            = cls;
    cls_count          = counted ? class_counters[cls_idx] + 32'd1 : 32'd0;
  end

  // Assemble the result word.
  always_comb begin
    result.status             = status;
    result.flag_class         = cls;
    result.source_address     = show_ip  ? addr_field_next[63:32] : 32'd0;
    result.dest_address       = show_ip  ? addr_field_next[31:0]  : 32'd0;
    result.source_port        = show_tcp ? tcp_field_next[63:48]  : 16'd0;
    result.dest_port          = show_tcp ? tcp_field_next[47:32]  : 16'd0;
    result.sequence_number    = show_tcp ? tcp_field_next[31:0]   : 32'd0;
    result.acknowledge_number = show_tcp ? ack_field_next         : 32'd0;
    result.packet_number      = frame_counter_next;
    result.class_count        = cls_count;
  end

  // Byte counter: saturates, returns to zero after the final byte.
  always_comb begin
    byte_offset_next = byte_offset;
    if (accept) begin
      if (s_axis_tlast) begin
        byte_offset_next = '0;
      end else if (byte_offset < OFFSET_CAP) begin
        byte_offset_next = byte_offset + OFFSET_W'(1);
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= '0;
      ip_header_bytes  <= '0;
      tcp_header_bytes <= '0;
      protocol_byte    <= '0;
      addr_field       <= '0;
      tcp_field        <= '0;
      ack_field        <= '0;
      flag_bits        <= '0;
    end else begin
      byte_offset <= byte_offset_next;
      if (accept) begin
        if (s_axis_tlast) begin
          ip_header_bytes  <= '0;
          tcp_header_bytes <= '0;
          protocol_byte    <= '0;
          addr_field       <= '0;
          tcp_field        <= '0;
          ack_field        <= '0;
          flag_bits        <= '0;
        end else begin
          ip_header_bytes  <= ip_header_bytes_next;
          tcp_header_bytes <= tcp_header_bytes_next;
          protocol_byte    <= protocol_byte_next;
          addr_field       <= addr_field_next;
          tcp_field        <= tcp_field_next;
          ack_field        <= ack_field_next;
          flag_bits        <= flag_bits_next;
        end
      end
    end
  end

  // Packet and class counters, advanced at most once per finished frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= 32'd1;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_counters[i] <= '0;
      end
    end else if (push) begin
      frame_counter <= frame_counter_next;
      if (counted) begin
        class_counters[cls_idx] <= cls_count;
      end
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        out_valid  <= skid_valid || push;
        skid_valid <= skid_valid && push;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_word <= skid_word;
        if (push) begin
          skid_word <= result;
        end
      end else if (push) begin
        out_word <= result;
      end
    end else if (push) begin
      skid_word <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_word.class_count, out_word.packet_number,
                          out_word.acknowledge_number, out_word.sequence_number,
                          out_word.dest_port, out_word.source_port,
                          out_word.dest_address, out_word.source_address};
  assign m_axis_tuser  = {out_word.flag_class, out_word.status};

  // The skid entry only fills behind a held output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while output register empty");

  // The byte counter restarts after every final byte.
  a_offset_restart: assert property (@(posedge clk) disable iff (rst)
    push |=> byte_offset == '0)
    else $error("byte counter did not restart after final byte");

  // The packet counter advances by at most one per cycle, and only on a final byte.
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    !push |=> frame_counter == $past(frame_counter))
    else $error("packet counter moved without a finished frame");

  // A failed frame is never classified or counted.
  a_fail_unclassified: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2:0] != ST_OK) |->
      (m_axis_tuser[5:3] == CLS_OTHER && m_axis_tdata[223:192] == 32'd0))
    else $error("failed frame carries a class or a count");

endmodule
